// ===== hw/rtl/running_mean_accumulator_macros.svh =====
// Assertion macros used by the running mean accumulator checker
`ifndef RUNNING_MEAN_ACCUMULATOR_MACROS_SVH
`define RUNNING_MEAN_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, idle during reset
`define RMA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rma assertion failed");

// Next-cycle implication, idle during reset
`define RMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rma assertion failed");

// What must hold on the cycle after reset is applied
`define RMA_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("rma reset assertion failed");

`endif

// ===== hw/rtl/rma_pkg.sv =====
// Package: types and constants of the running mean accumulator
`timescale 1ns / 1ps
package rma_pkg;

  localparam int SUM_W       = 64;
  localparam int COUNT_W     = 32;
  localparam int VALUE_W     = 32;
  localparam int RCOUNT_W    = 31;
  localparam int STEP_BITS   = 2;
  localparam int DIV_STEPS   = SUM_W / STEP_BITS;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam int LIST_LIMIT_DEF  = 256;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_BANG  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_LIST  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]                 command;
    logic signed [VALUE_W-1:0]  value;
    logic                       not_finite;
    logic                       list_first;
    logic                       list_last;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  mean;
    logic [RCOUNT_W-1:0]        reported_count;
    logic                       count_full;
  } out_t;

  // Snapshot of the state that a report divides
  typedef struct packed {
    logic signed [SUM_W-1:0]    sum;
    logic [COUNT_W-1:0]         count;
    logic                       full;
  } rep_t;

endpackage

// ===== hw/rtl/running_mean_accumulator.sv =====
// Top level of the running mean accumulator
//
//   port group  direction  payload   transfer when
//   in_*        input      in_t      in_valid && in_ready
//   out_*       output     out_t     out_valid && out_ready
//
// The front takes one command per cycle while the report queue has room;
// add, bang and list-last commands push a report, the rest push nothing.
// Each report passes through the back in order: a load, 32 steps of the
// 2-bit-per-cycle 64 by 32 divider, and a write of the output register.
// A stalled output holds the back, then fills the queue, then drops in_ready.
// Reset is synchronous and clears sum, count, list position and flags.
`timescale 1ns / 1ps
module running_mean_accumulator #(
  parameter int LIST_LIMIT  = rma_pkg::LIST_LIMIT_DEF,
  parameter int QUEUE_DEPTH = rma_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rma_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rma_pkg::out_t  out_data
);
  import rma_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  rep_t push_data, pop_data;

  rma_front #(
    .LIST_LIMIT (LIST_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rma_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rma_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/rma_front.sv =====
// Front end: accepts commands, keeps sum, count and list state, queues reports
`timescale 1ns / 1ps
module rma_front #(
  parameter int LIST_LIMIT = rma_pkg::LIST_LIMIT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rma_pkg::in_t   in_data,
  output logic           push_valid,
  input  logic           push_ready,
  output rma_pkg::rep_t  push_data
);
  import rma_pkg::*;

  localparam int POS_W = $clog2(LIST_LIMIT + 1);

  logic signed [SUM_W-1:0] sum, sum_next;
  logic [COUNT_W-1:0]      count, count_next;
  logic [POS_W-1:0]        pos, pos_next;
  logic                    full, full_next;
  logic                    reports;
  logic                    accept;
  logic signed [SUM_W-1:0] addend;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign addend   = in_data.not_finite ? '0
                  : {{(SUM_W-VALUE_W){in_data.value[VALUE_W-1]}}, in_data.value};

  always_comb begin
    logic do_fold;
    sum_next   = sum;
    count_next = count;
    pos_next   = pos;
    full_next  = full;
    reports    = 1'b0;
    do_fold    = 1'b0;
    unique case (cmd_t'(in_data.command))
      CMD_ADD: begin
        do_fold = 1'b1;
        reports = 1'b1;
      end
      CMD_BANG: begin
        reports = 1'b1;
      end
      CMD_CLEAR: begin
        sum_next   = '0;
        count_next = '0;
        pos_next   = '0;
        full_next  = 1'b0;
      end
      CMD_LIST: begin
        if (in_data.list_first) begin
          sum_next   = '0;
          count_next = '0;
          pos_next   = '0;
          full_next  = 1'b0;
        end
        // elements past the limit add nothing
        if (pos_next < POS_W'(LIST_LIMIT)) begin
          do_fold  = 1'b1;
          pos_next = pos_next + 1'b1;
        end
        reports = in_data.list_last;
      end
    endcase
    if (do_fold) begin
      if (count_next == '1) begin
        full_next = 1'b1;
      end else begin
        sum_next   = sum_next + addend;
        count_next = count_next + 1'b1;
      end
    end
  end

  assign push_valid      = in_valid && reports;
  assign push_data.sum   = sum_next;
  assign push_data.count = count_next;
  assign push_data.full  = full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
      pos   <= '0;
      full  <= 1'b0;
    end else if (accept) begin
      sum   <= sum_next;
      count <= count_next;
      pos   <= pos_next;
      full  <= full_next;
    end
  end

endmodule

// ===== hw/rtl/rma_queue.sv =====
// Short register queue of pending reports between front and back
`timescale 1ns / 1ps
module rma_queue #(
  parameter int DEPTH = rma_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  rma_pkg::rep_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rma_pkg::rep_t  pop_data
);
  import rma_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rep_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push, pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/rma_back.sv =====
// Back end: radix-4 restoring divider and output register for reports
`timescale 1ns / 1ps
module rma_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  rma_pkg::rep_t  pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rma_pkg::out_t  out_data
);
  import rma_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t               state, state_next;
  logic [SUM_W-1:0]     quo;
  logic [COUNT_W:0]     rem;
  logic [COUNT_W-1:0]   divisor;
  logic [STEP_W-1:0]    step;
  logic                 neg, zero_div, full_r;
  logic [RCOUNT_W-1:0]  rcount;

  logic [COUNT_W:0]     r1, r1s, r2, r2s;
  logic                 ge1, ge2;
  logic                 load, finish;
  logic [VALUE_W-1:0]   q_lo;

  assign pop_ready = (state == ST_IDLE);
  assign load      = pop_valid && pop_ready;
  assign finish    = (state == ST_HOLD) && (!out_valid || out_ready);

  // two quotient bits per cycle while in the run state
  always_comb begin
    r1  = {rem[COUNT_W-1:0], quo[SUM_W-1]};
    ge1 = (r1 >= {1'b0, divisor});
    r1s = ge1 ? r1 - {1'b0, divisor} : r1;
    r2  = {r1s[COUNT_W-1:0], quo[SUM_W-2]};
    ge2 = (r2 >= {1'b0, divisor});
    r2s = ge2 ? r2 - {1'b0, divisor} : r2;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (load) state_next = ST_RUN;
      ST_RUN:  if (step == STEP_W'(DIV_STEPS - 1)) state_next = ST_HOLD;
      ST_HOLD: if (finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg      <= pop_data.sum[SUM_W-1];
      quo      <= pop_data.sum[SUM_W-1] ? SUM_W'(0) - pop_data.sum : pop_data.sum;
      rem      <= '0;
      divisor  <= pop_data.count;
      zero_div <= (pop_data.count == '0);
      full_r   <= pop_data.full;
      rcount   <= pop_data.count[COUNT_W-1] ? '1 : pop_data.count[RCOUNT_W-1:0];
      step     <= '0;
    end else if (state == ST_RUN) begin
      quo  <= {quo[SUM_W-3:0], ge1, ge2};
      rem  <= r2s;
      step <= step + 1'b1;
    end
  end

  // mean keeps the low word of the signed quotient
  assign q_lo = quo[VALUE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data.mean           <= zero_div ? '0 : (neg ? VALUE_W'(0) - q_lo : q_lo);
      out_data.reported_count <= rcount;
      out_data.count_full     <= full_r;
    end
  end

endmodule

// ===== hw/rtl/rma_checker.sv =====
// Port-level checker for the running mean accumulator, bound to the top level
`timescale 1ns / 1ps
`include "running_mean_accumulator_macros.svh"
module rma_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input rma_pkg::out_t  out_data
);
  import rma_pkg::*;

  `RMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `RMA_ASSERT_NOW(a_full_saturated, out_valid && out_data.count_full, out_data.reported_count == '1)
  `RMA_ASSERT_NOW(a_empty_mean, out_valid && (out_data.reported_count == '0), out_data.mean == '0)
  `RMA_ASSERT_RESET(a_reset_idle, !out_valid)

endmodule

bind running_mean_accumulator rma_checker u_rma_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
